@@ src/fbrc_pkg.sv @@
// ----------------------------------------------------------------------------
// fbrc_pkg: shared types and constants of the freed block reuse cache
// Sizes, widths, register indexes, controller states and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package fbrc_pkg;

  // Number of cache entries.
  localparam int MAX_BLOCKS = 16;

  localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
  localparam int SIZE_W   = 32;
  localparam int RSIZE_W  = 33;
  localparam int HANDLE_W = 48;
  localparam int ALIGN_W  = 16;
  localparam int MAXB_W   = 5;
  localparam int LIM_W    = (CNT_W > MAXB_W) ? CNT_W : MAXB_W;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // Remainder unit: bits retired per cycle and the resulting step count.
  localparam int DIV_BITS   = 4;
  localparam int DIV_STEPS  = SIZE_W / DIV_BITS;
  localparam int DIVCNT_W   = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BLOCKS = CFG_IDX_W'(1);

  localparam logic [MAXB_W-1:0] MAXB_RESET = MAXB_W'(16);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_ROUND,
    ST_SCAN,
    ST_FETCH,
    ST_HIT,
    ST_MISS,
    ST_INSERT,
    ST_CHECK,
    ST_EVICT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    RD_SCAN,
    RD_BEST,
    RD_OLDEST
  } rd_sel_t;

  typedef struct packed {
    logic    accept;
    logic    div_step;
    logic    round_load;
    logic    scan_start;
    logic    scan_step;
    rd_sel_t rd_sel;
    logic    hit_take;
    logic    miss_take;
    logic    insert;
    logic    free_keep;
    logic    evict_take;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic scan_done;
    logic found;
    logic evict_need;
  } sts_t;

  typedef struct packed {
    logic [SIZE_W-1:0]   size;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic                hit;
    logic [HANDLE_W-1:0] reused_handle;
    logic [RSIZE_W-1:0]  rounded_size;
    logic                evicted;
    logic [HANDLE_W-1:0] evicted_handle;
  } res_t;

endpackage

@@ src/fbrc_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbrc_ctrl: sequencing controller
// Walks an allocate through rounding and best-fit scan and a free through
// insert and eviction, and owns the input ready and the output valid flag.
// ----------------------------------------------------------------------------
module fbrc_ctrl
  import fbrc_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_mode,
  output logic   in_ready,
  input  logic   out_ready,
  output logic   out_valid,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.out_load | (out_valid_r & ~out_ready);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_mode ? ST_INSERT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = sts.found ? ST_FETCH : ST_MISS;
        end
      end
      ST_FETCH:  state_nxt = ST_HIT;
      ST_HIT:    state_nxt = ST_DONE;
      ST_MISS:   state_nxt = ST_DONE;
      ST_INSERT: state_nxt = ST_CHECK;
      ST_CHECK:  state_nxt = sts.evict_need ? ST_EVICT : ST_DONE;
      ST_EVICT:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.rd_sel = RD_SCAN;
    unique case (state_r)
      ST_IDLE:   cmd.accept     = in_valid;
      ST_DIV:    cmd.div_step   = 1'b1;
      ST_ROUND: begin
        cmd.round_load = 1'b1;
        cmd.scan_start = 1'b1;
      end
      ST_SCAN:   cmd.scan_step  = 1'b1;
      ST_FETCH:  cmd.rd_sel     = RD_BEST;
      ST_HIT:    cmd.hit_take   = 1'b1;
      ST_MISS:   cmd.miss_take  = 1'b1;
      ST_INSERT: cmd.insert     = 1'b1;
      ST_CHECK: begin
        cmd.rd_sel    = RD_OLDEST;
        cmd.free_keep = ~sts.evict_need;
      end
      ST_EVICT:  cmd.evict_take = 1'b1;
      ST_DONE:   cmd.out_load   = ~out_valid_r | out_ready;
      default:   cmd.accept     = 1'b0;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ src/fbrc_dp.sv @@
// ----------------------------------------------------------------------------
// fbrc_dp: cache datapath
// Entry memory, valid bits and age ranks, the remainder unit for rounding,
// the best-fit comparator, configuration registers and the result register.
// ----------------------------------------------------------------------------
module fbrc_dp
  import fbrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [SIZE_W-1:0]     in_size,
  input  logic [HANDLE_W-1:0]   in_handle,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output res_t                  out_res
);

  // Configuration.
  logic [ALIGN_W-1:0] align_r;
  logic [MAXB_W-1:0]  maxb_r;

  // Item and rounding.
  logic [SIZE_W-1:0]   in_size_r;
  logic [HANDLE_W-1:0] in_handle_r;
  logic [SIZE_W-1:0]   dvd_r;
  logic [ALIGN_W-1:0]  rem_r, rem_nxt;
  logic [DIVCNT_W-1:0] div_cnt_r;
  logic [RSIZE_W-1:0]  req_r;

  // Entry bookkeeping.
  logic             valid_r   [MAX_BLOCKS];
  logic             valid_nxt [MAX_BLOCKS];
  logic [IDX_W-1:0] rank_r    [MAX_BLOCKS];
  logic [IDX_W-1:0] rank_nxt  [MAX_BLOCKS];
  logic [CNT_W-1:0] count_r, count_nxt;

  entry_t           mem [MAX_BLOCKS];
  entry_t           mem_rd_r;
  logic [IDX_W-1:0] rd_addr;

  // Scan.
  logic [CNT_W-1:0]  scan_cnt_r;
  logic              cmp_en_r;
  logic [IDX_W-1:0]  cmp_idx_r;
  logic              found_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [SIZE_W-1:0] best_size_r;
  logic              take_better;

  logic [IDX_W-1:0] free_idx;
  logic [IDX_W-1:0] oldest_idx;
  logic [IDX_W-1:0] oldest_rank;
  logic [IDX_W-1:0] drop_idx;
  logic [LIM_W-1:0] eff_lim;

  res_t res_r, out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      align_r <= '0;
      maxb_r  <= MAXB_RESET;
    end else if (cfg_we) begin
      if (cfg_index == REG_ALIGNMENT) begin
        align_r <= cfg_wdata[ALIGN_W-1:0];
      end else if (cfg_index == REG_MAX_BLOCKS) begin
        maxb_r <= cfg_wdata[MAXB_W-1:0];
      end
    end
  end

  // Remainder of size by alignment, DIV_BITS quotient bits per cycle.
  always_comb begin
    logic [ALIGN_W:0]   trial;
    logic [ALIGN_W-1:0] rem_v;
    rem_v = rem_r;
    trial = '0;
    for (int k = 0; k < DIV_BITS; k++) begin
      trial = {rem_v, dvd_r[SIZE_W-1-k]};
      if (trial >= {1'b0, align_r}) begin
        trial = trial - {1'b0, align_r};
      end
      rem_v = trial[ALIGN_W-1:0];
    end
    rem_nxt = rem_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_size_r   <= in_size;
      in_handle_r <= in_handle;
      dvd_r       <= in_size;
      rem_r       <= '0;
      div_cnt_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r     <= dvd_r << DIV_BITS;
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + DIVCNT_W'(1);
    end
    if (cmd.round_load) begin
      if (align_r == '0 || rem_r == '0) begin
        req_r <= RSIZE_W'(in_size_r);
      end else begin
        req_r <= RSIZE_W'(in_size_r) + RSIZE_W'(align_r) - RSIZE_W'(rem_r);
      end
    end
  end

  // First free entry and the oldest valid entry (rank count - 1).
  assign oldest_rank = IDX_W'(count_r - CNT_W'(1));

  always_comb begin
    free_idx   = '0;
    oldest_idx = '0;
    for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (valid_r[i] && rank_r[i] == oldest_rank) begin
        oldest_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    if (maxb_r == '0) begin
      eff_lim = LIM_W'(1);
    end else if (LIM_W'(maxb_r) > LIM_W'(MAX_BLOCKS)) begin
      eff_lim = LIM_W'(MAX_BLOCKS);
    end else begin
      eff_lim = LIM_W'(maxb_r);
    end
  end

  assign drop_idx = cmd.hit_take ? best_idx_r : oldest_idx;

  always_comb begin
    valid_nxt = valid_r;
    rank_nxt  = rank_r;
    count_nxt = count_r;
    if (cmd.insert) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (valid_r[i]) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
      valid_nxt[free_idx] = 1'b1;
      rank_nxt[free_idx]  = '0;
      count_nxt           = count_r + CNT_W'(1);
    end else if (cmd.hit_take || cmd.evict_take) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        if (valid_r[i] && rank_r[i] > rank_r[drop_idx]) begin
          rank_nxt[i] = rank_r[i] - IDX_W'(1);
        end
      end
      valid_nxt[drop_idx] = 1'b0;
      rank_nxt[drop_idx]  = '0;
      count_nxt           = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        valid_r[i] <= 1'b0;
        rank_r[i]  <= '0;
      end
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      rank_r  <= rank_nxt;
      count_r <= count_nxt;
    end
  end

  // Entry memory: one write port, one registered read port.
  always_comb begin
    unique case (cmd.rd_sel)
      RD_SCAN:   rd_addr = scan_cnt_r[IDX_W-1:0];
      RD_BEST:   rd_addr = best_idx_r;
      RD_OLDEST: rd_addr = oldest_idx;
      default:   rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      mem[free_idx] <= '{size: in_size_r, handle: in_handle_r};
    end
    mem_rd_r <= mem[rd_addr];
  end

  // Best fit: smallest size not below the request, newest on a tie.
  assign take_better = cmp_en_r && valid_r[cmp_idx_r] &&
                       (RSIZE_W'(mem_rd_r.size) >= req_r) &&
                       (!found_r || mem_rd_r.size < best_size_r ||
                        (mem_rd_r.size == best_size_r &&
                         rank_r[cmp_idx_r] < rank_r[best_idx_r]));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_cnt_r <= '0;
      cmp_en_r   <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.scan_start) begin
      scan_cnt_r <= '0;
      cmp_en_r   <= 1'b0;
      found_r    <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_cnt_r != CNT_W'(MAX_BLOCKS)) begin
        scan_cnt_r <= scan_cnt_r + CNT_W'(1);
      end
      cmp_en_r <= (scan_cnt_r != CNT_W'(MAX_BLOCKS));
      if (take_better) begin
        found_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      cmp_idx_r <= scan_cnt_r[IDX_W-1:0];
      if (take_better) begin
        best_idx_r  <= cmp_idx_r;
        best_size_r <= mem_rd_r.size;
      end
    end
  end

  // Result staging and the output register.
  always_ff @(posedge clk) begin
    if (cmd.hit_take) begin
      res_r <= '{hit: 1'b1, reused_handle: mem_rd_r.handle, rounded_size: req_r,
                 evicted: 1'b0, evicted_handle: '0};
    end else if (cmd.miss_take) begin
      res_r <= '{hit: 1'b0, reused_handle: '0, rounded_size: req_r,
                 evicted: 1'b0, evicted_handle: '0};
    end else if (cmd.free_keep) begin
      res_r <= '0;
    end else if (cmd.evict_take) begin
      res_r <= '{hit: 1'b0, reused_handle: '0, rounded_size: '0,
                 evicted: 1'b1, evicted_handle: mem_rd_r.handle};
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  assign sts.div_last   = (div_cnt_r == DIVCNT_W'(DIV_STEPS - 1));
  assign sts.scan_done  = (scan_cnt_r == CNT_W'(MAX_BLOCKS)) && !cmp_en_r;
  assign sts.found      = found_r;
  assign sts.evict_need = (LIM_W'(count_r) >= eff_lim);

  assign out_res = out_r;

endmodule

@@ src/freed_block_reuse_cache_top.sv @@
// ----------------------------------------------------------------------------
// freed_block_reuse_cache_top: cache of freed blocks with best-fit reuse
// Keeps up to fifteen freed (handle, size) blocks in age order, hands back
// the best-fitting one on allocate and evicts the oldest one on overflow.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on the in_ channel (valid/ready). in_mode 0 is an allocate
// of in_size bytes; in_mode 1 frees the block in_handle of in_size bytes.
// Every item yields exactly one result transfer on the out_ channel.
// The cfg_ channel writes alignment (index 0) and max_blocks (index 1); it is
// always ready, and other indexes are ignored. Write it only while idle.
// Steps: an allocate runs the remainder unit (four bits of the size per
// cycle), then a rounding step, then a walk over the entry memory, which
// has a single registered read port; a hit then reads the best entry. A
// free inserts the block and checks the limit, and evicts when the limit
// is reached. One item is in work at a time; in_ready returns the cycle
// after its result is loaded into the output register.
// The output register holds a finished result while out_ready is low; the
// next item is still accepted and worked on, and only its own completion
// waits for the register to free up.
// Reset (synchronous, rst_n low) empties the cache, clears the output valid
// flag and sets alignment to 0 and max_blocks to 16.
// ----------------------------------------------------------------------------
module freed_block_reuse_cache_top
  import fbrc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input items.
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_mode,
  input  logic [SIZE_W-1:0]     in_size,
  input  logic [HANDLE_W-1:0]   in_handle,
  // Results.
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit,
  output logic [HANDLE_W-1:0]   out_reused_handle,
  output logic [RSIZE_W-1:0]    out_rounded_size,
  output logic                  out_evicted,
  output logic [HANDLE_W-1:0]   out_evicted_handle,
  // Configuration writes.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  res_t res;

  // Register writes never stall.
  assign cfg_ready = 1'b1;

  fbrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_mode   (in_mode),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_size   (in_size),
    .in_handle (in_handle),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .out_res   (res)
  );

  assign out_hit            = res.hit;
  assign out_reused_handle  = res.reused_handle;
  assign out_rounded_size   = res.rounded_size;
  assign out_evicted        = res.evicted;
  assign out_evicted_handle = res.evicted_handle;

`ifndef SYNTH
  // Only one item is in work: ready drops right after an input transfer.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while an item is in work");

  // A held result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid || out_ready))
    else $error("output register loaded while a result is held");

  // A result is either a reuse or an eviction, never both.
  a_hit_xor_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_hit && out_evicted))
    else $error("result reports both a hit and an eviction");

  // At most one result source is taken per cycle.
  a_one_take: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.hit_take, cmd.miss_take, cmd.free_keep, cmd.evict_take}))
    else $error("more than one result source in one cycle");
`endif

endmodule
